>>> sv/scpcsr_pkg.sv
// Shared types and constants for the sparse column permute / CSR build block.
// No dependencies; used by sparse_column_permute_csr_build.
package scpcsr_pkg;

  localparam int LINK_W = 13;   // pointers, positions, links
  localparam int IDX_W  = 11;   // row / column indices
  localparam int VAL_W  = 64;   // raw entry value
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W  = 13;

  localparam int DEF_MAX_DIM      = 1024;
  localparam int DEF_MAX_NONZEROS = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_NZ_COUNT  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD_COLPTR = 3'd0,
    OP_LOAD_ENTRY  = 3'd1,
    OP_LOAD_PERM   = 3'd2,
    OP_RUN         = 3'd3,
    OP_READ_COLPTR = 3'd4,
    OP_READ_CSC    = 3'd5,
    OP_READ_ROWPTR = 3'd6,
    OP_READ_CSR    = 3'd7
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_CK_PERM,
    ST_CK_START,
    ST_CK_END,
    ST_CK_ROW,
    ST_CK_TAIL,
    ST_CP_PERM,
    ST_CP_START,
    ST_CP_END,
    ST_CP_WR,
    ST_CP_LAST,
    ST_CLR,
    ST_HI_ROW,
    ST_HI_WR,
    ST_PF_START,
    ST_PF_WR,
    ST_PF_LAST,
    ST_SC_ROW,
    ST_SC_WR,
    ST_FIN
  } state_t;

endpackage

>>> sv/sparse_column_permute_csr_build.sv
// Sparse column permutation with CSR build, top level.
// Depends on scpcsr_pkg and scpcsr_ram.
//
// Usage:
//   Slave stream (s_*) takes commands: s_tuser = operation, s_tdata holds
//   position, link and value. Master stream (m_*) returns one result per
//   command: m_tdata holds result_link and result_value, m_tuser = status.
//   cfg_we/cfg_index/cfg_wdata write row_count, col_count, nonzero_count;
//   write them only while no command is in flight.
// Sequencing:
//   Loads and out-of-range commands finish in the accept cycle; the result
//   sits in the output register the next cycle, one per cycle unless the
//   receiver stalls. Reads pass the RAM read port, then the output register.
//   A run walks the stores one RAM port access at a time, set by the
//   single read port of each memory: check, copy, clear, row histogram,
//   prefix and scatter.
// Reset clears control and the configuration registers; stores hold
// garbage until loaded or built. A stalled receiver holds the output
// register, and no new command is taken until it drains.
module sparse_column_permute_csr_build #(
  parameter int MAX_DIM      = scpcsr_pkg::DEF_MAX_DIM,
  parameter int MAX_NONZEROS = scpcsr_pkg::DEF_MAX_NONZEROS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // position[12:0], link[25:13], value_bits[89:26], zero pad
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // result_link[12:0], result_value[76:13], zero pad
  output logic        m_tuser,   // status
  input  logic        cfg_we,
  input  logic [scpcsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpcsr_pkg::CFG_W-1:0]     cfg_wdata
);
  localparam int LW  = scpcsr_pkg::LINK_W;
  localparam int IW  = scpcsr_pkg::IDX_W;
  localparam int VW  = scpcsr_pkg::VAL_W;
  localparam int DD  = MAX_DIM + 2;          // pointer store depth
  localparam int PD  = MAX_DIM + 1;          // permutation depth
  localparam int ND  = MAX_NONZEROS + 1;     // entry store depth
  localparam int DAW = $clog2(DD);
  localparam int PAW = $clog2(PD);
  localparam int NAW = $clog2(ND);
  localparam int NCW = $clog2(MAX_NONZEROS + 2);
  localparam int TW  = ((NCW > LW) ? NCW : LW) + 1;

  // configuration
  logic [10:0] row_count, col_count;
  logic [12:0] nonzero_count;
  logic [DAW-1:0] n_eff, m_eff;
  logic [NCW-1:0] nz_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= 11'd1;
      col_count     <= 11'd1;
      nonzero_count <= 13'd0;
    end else if (cfg_we) begin
      case (scpcsr_pkg::reg_idx_t'(cfg_index))
        scpcsr_pkg::REG_ROW_COUNT: row_count     <= cfg_wdata[10:0];
        scpcsr_pkg::REG_COL_COUNT: col_count     <= cfg_wdata[10:0];
        scpcsr_pkg::REG_NZ_COUNT:  nonzero_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_eff  = (32'(col_count) > MAX_DIM) ? DAW'(MAX_DIM) : DAW'(col_count);
  assign m_eff  = (32'(row_count) > MAX_DIM) ? DAW'(MAX_DIM) : DAW'(row_count);
  assign nz_eff = (32'(nonzero_count) > MAX_NONZEROS) ? NCW'(MAX_NONZEROS)
                                                      : NCW'(nonzero_count);

  // input fields
  scpcsr_pkg::op_t op_in;
  logic [LW-1:0] pos, lnk;
  logic [VW-1:0] val;
  assign op_in = scpcsr_pkg::op_t'(s_tuser);
  assign pos   = s_tdata[12:0];
  assign lnk   = s_tdata[25:13];
  assign val   = s_tdata[89:26];

  // memories
  logic           scs_we, scs_re;   logic [DAW-1:0] scs_wa, scs_ra; logic [LW-1:0] scs_wd, scs_rd;
  logic           sri_we, sri_re;   logic [NAW-1:0] sri_wa, sri_ra; logic [IW-1:0] sri_wd, sri_rd;
  logic [VW-1:0]  sval_rd;
  logic           prm_we, prm_re;   logic [PAW-1:0] prm_wa, prm_ra; logic [IW-1:0] prm_wd, prm_rd;
  logic           pcs_we, pcs_re;   logic [DAW-1:0] pcs_wa, pcs_ra; logic [LW-1:0] pcs_wd, pcs_rd;
  logic           pri_we, pri_re;   logic [NAW-1:0] pri_wa, pri_ra; logic [IW-1:0] pri_wd, pri_rd;
  logic [VW-1:0]  pval_wd, pval_rd;
  logic [IW-1:0]  ecol_wd, ecol_rd;
  logic           ent_re;           // pval/ecol read with pri in scatter and CSC reads
  logic           rn_we, rn_re;     logic [DAW-1:0] rn_wa, rn_ra;   logic [NCW-1:0] rn_wd, rn_rd;
  logic           rs_we, rs_re;     logic [DAW-1:0] rs_wa, rs_ra;   logic [LW-1:0] rs_wd, rs_rd;
  logic           rc_we, rc_re;     logic [NAW-1:0] rc_wa, rc_ra;   logic [IW-1:0] rc_wd, rc_rd;
  logic [VW-1:0]  rval_wd, rval_rd;

  scpcsr_ram #(.W(LW), .D(DD)) u_scs (.clk, .we(scs_we), .waddr(scs_wa), .wdata(scs_wd),
    .re(scs_re), .raddr(scs_ra), .rdata(scs_rd));
  scpcsr_ram #(.W(IW), .D(ND)) u_sri (.clk, .we(sri_we), .waddr(sri_wa), .wdata(sri_wd),
    .re(sri_re), .raddr(sri_ra), .rdata(sri_rd));
  scpcsr_ram #(.W(VW), .D(ND)) u_sval (.clk, .we(sri_we), .waddr(sri_wa), .wdata(val),
    .re(sri_re), .raddr(sri_ra), .rdata(sval_rd));
  scpcsr_ram #(.W(IW), .D(PD)) u_prm (.clk, .we(prm_we), .waddr(prm_wa), .wdata(prm_wd),
    .re(prm_re), .raddr(prm_ra), .rdata(prm_rd));
  scpcsr_ram #(.W(LW), .D(DD)) u_pcs (.clk, .we(pcs_we), .waddr(pcs_wa), .wdata(pcs_wd),
    .re(pcs_re), .raddr(pcs_ra), .rdata(pcs_rd));
  scpcsr_ram #(.W(IW), .D(ND)) u_pri (.clk, .we(pri_we), .waddr(pri_wa), .wdata(pri_wd),
    .re(pri_re), .raddr(pri_ra), .rdata(pri_rd));
  scpcsr_ram #(.W(VW), .D(ND)) u_pval (.clk, .we(pri_we), .waddr(pri_wa), .wdata(pval_wd),
    .re(ent_re), .raddr(pri_ra), .rdata(pval_rd));
  scpcsr_ram #(.W(IW), .D(ND)) u_ecol (.clk, .we(pri_we), .waddr(pri_wa), .wdata(ecol_wd),
    .re(ent_re), .raddr(pri_ra), .rdata(ecol_rd));
  scpcsr_ram #(.W(NCW), .D(DD)) u_rn (.clk, .we(rn_we), .waddr(rn_wa), .wdata(rn_wd),
    .re(rn_re), .raddr(rn_ra), .rdata(rn_rd));
  scpcsr_ram #(.W(LW), .D(DD)) u_rs (.clk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd),
    .re(rs_re), .raddr(rs_ra), .rdata(rs_rd));
  scpcsr_ram #(.W(IW), .D(ND)) u_rc (.clk, .we(rc_we), .waddr(rc_wa), .wdata(rc_wd),
    .re(rc_re), .raddr(rc_ra), .rdata(rc_rd));
  scpcsr_ram #(.W(VW), .D(ND)) u_rval (.clk, .we(rc_we), .waddr(rc_wa), .wdata(rval_wd),
    .re(rc_re), .raddr(rc_ra), .rdata(rval_rd));

  // control / datapath registers
  scpcsr_pkg::state_t state, state_next;
  scpcsr_pkg::op_t    op_reg, op_reg_next;
  logic [DAW-1:0] col, col_next;       // column counter, also row counter
  logic [IW-1:0]  src, src_next;
  logic [LW-1:0]  s_ptr, s_ptr_next, e_ptr, e_ptr_next, j, j_next;
  logic [TW-1:0]  total, total_next;
  logic [NCW-1:0] count, count_next, k, k_next;
  logic [IW-1:0]  rr, rr_next;
  logic           err, err_next;

  // output register
  logic           out_valid, out_load, out_status, out_status_next;
  logic [LW-1:0]  out_link, out_link_next;
  logic [VW-1:0]  out_value, out_value_next;

  logic           accept;
  logic [TW-1:0]  tsum;
  logic           in_dim1, in_nz, lnk_row, lnk_col, pos_col, pos_row1;

  assign s_tready = (state == scpcsr_pkg::ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign in_dim1  = (pos != '0) && (32'(pos) <= 32'(n_eff) + 1);
  assign pos_col  = (pos != '0) && (32'(pos) <= 32'(n_eff));
  assign pos_row1 = (pos != '0) && (32'(pos) <= 32'(m_eff) + 1);
  assign in_nz    = (pos != '0) && (32'(pos) <= 32'(nz_eff));
  assign lnk_row  = (lnk != '0) && (32'(lnk) <= 32'(m_eff));
  assign lnk_col  = (lnk != '0) && (32'(lnk) <= 32'(n_eff));
  assign tsum     = total + TW'(scs_rd - s_ptr);

  always_comb begin
    state_next = state;
    op_reg_next = op_reg;
    col_next = col; src_next = src; s_ptr_next = s_ptr; e_ptr_next = e_ptr;
    j_next = j; total_next = total; count_next = count; k_next = k;
    rr_next = rr; err_next = err;
    out_load = 1'b0; out_status_next = 1'b0; out_link_next = '0; out_value_next = '0;

    scs_we = 1'b0; scs_wa = DAW'(pos); scs_wd = lnk; scs_re = 1'b0; scs_ra = DAW'(src);
    sri_we = 1'b0; sri_wa = NAW'(pos); sri_wd = IW'(lnk); sri_re = 1'b0; sri_ra = NAW'(j);
    prm_we = 1'b0; prm_wa = PAW'(pos); prm_wd = IW'(lnk); prm_re = 1'b0; prm_ra = PAW'(col);
    pcs_we = 1'b0; pcs_wa = DAW'(col); pcs_wd = LW'(count); pcs_re = 1'b0; pcs_ra = DAW'(pos);
    pri_we = 1'b0; pri_wa = NAW'(count); pri_wd = sri_rd; pri_re = 1'b0; pri_ra = NAW'(pos);
    pval_wd = sval_rd; ecol_wd = IW'(col); ent_re = 1'b0;
    rn_we = 1'b0; rn_wa = DAW'(col); rn_wd = '0; rn_re = 1'b0; rn_ra = DAW'(col);
    rs_we = 1'b0; rs_wa = DAW'(col); rs_wd = LW'(count); rs_re = 1'b0; rs_ra = DAW'(pos);
    rc_we = 1'b0; rc_wa = NAW'(rn_rd); rc_wd = ecol_rd; rc_re = 1'b0; rc_ra = NAW'(pos);
    rval_wd = pval_rd;

    case (state)
      scpcsr_pkg::ST_IDLE: begin
        if (accept) begin
          op_reg_next = op_in;
          case (op_in)
            scpcsr_pkg::OP_LOAD_COLPTR: begin
              out_load = 1'b1; out_status_next = !in_dim1; scs_we = in_dim1;
            end
            scpcsr_pkg::OP_LOAD_ENTRY: begin
              out_load = 1'b1; out_status_next = !(in_nz && lnk_row);
              sri_we = in_nz && lnk_row;
            end
            scpcsr_pkg::OP_LOAD_PERM: begin
              out_load = 1'b1; out_status_next = !(pos_col && lnk_col);
              prm_we = pos_col && lnk_col;
            end
            scpcsr_pkg::OP_RUN: begin
              col_next = DAW'(1); total_next = '0; err_next = 1'b0;
              if (n_eff == '0) begin
                state_next = scpcsr_pkg::ST_CK_TAIL;
              end else begin
                prm_re = 1'b1; prm_ra = PAW'(1);
                state_next = scpcsr_pkg::ST_CK_PERM;
              end
            end
            scpcsr_pkg::OP_READ_COLPTR: begin
              if (in_dim1) begin
                pcs_re = 1'b1; state_next = scpcsr_pkg::ST_READ;
              end else begin
                out_load = 1'b1; out_status_next = 1'b1;
              end
            end
            scpcsr_pkg::OP_READ_CSC: begin
              if (in_nz) begin
                pri_re = 1'b1; ent_re = 1'b1; state_next = scpcsr_pkg::ST_READ;
              end else begin
                out_load = 1'b1; out_status_next = 1'b1;
              end
            end
            scpcsr_pkg::OP_READ_ROWPTR: begin
              if (pos_row1) begin
                rs_re = 1'b1; state_next = scpcsr_pkg::ST_READ;
              end else begin
                out_load = 1'b1; out_status_next = 1'b1;
              end
            end
            default: begin
              if (in_nz) begin
                rc_re = 1'b1; state_next = scpcsr_pkg::ST_READ;
              end else begin
                out_load = 1'b1; out_status_next = 1'b1;
              end
            end
          endcase
        end
      end

      scpcsr_pkg::ST_READ: begin
        out_load = 1'b1;
        state_next = scpcsr_pkg::ST_IDLE;
        case (op_reg)
          scpcsr_pkg::OP_READ_COLPTR: out_link_next = pcs_rd;
          scpcsr_pkg::OP_READ_CSC: begin
            out_link_next = LW'(pri_rd); out_value_next = pval_rd;
          end
          scpcsr_pkg::OP_READ_ROWPTR: out_link_next = rs_rd;
          default: begin
            out_link_next = LW'(rc_rd); out_value_next = rval_rd;
          end
        endcase
      end

      // ---- check pass ----
      scpcsr_pkg::ST_CK_PERM: begin
        src_next = prm_rd;
        if (prm_rd == '0 || 32'(prm_rd) > 32'(n_eff)) begin
          err_next = 1'b1; state_next = scpcsr_pkg::ST_FIN;
        end else begin
          scs_re = 1'b1; scs_ra = DAW'(prm_rd);
          state_next = scpcsr_pkg::ST_CK_START;
        end
      end

      scpcsr_pkg::ST_CK_START: begin
        s_ptr_next = scs_rd;
        scs_re = 1'b1; scs_ra = DAW'(src) + DAW'(1);
        state_next = scpcsr_pkg::ST_CK_END;
      end

      scpcsr_pkg::ST_CK_END: begin
        e_ptr_next = scs_rd;
        if (scs_rd > s_ptr) begin
          if (s_ptr == '0 || 32'(scs_rd) - 1 > 32'(nz_eff) || tsum > TW'(nz_eff)) begin
            err_next = 1'b1; state_next = scpcsr_pkg::ST_FIN;
          end else begin
            total_next = tsum; j_next = s_ptr;
            sri_re = 1'b1; sri_ra = NAW'(s_ptr);
            state_next = scpcsr_pkg::ST_CK_ROW;
          end
        end else if (col == n_eff) begin
          state_next = scpcsr_pkg::ST_CK_TAIL;
        end else begin
          col_next = col + DAW'(1);
          prm_re = 1'b1; prm_ra = PAW'(col + DAW'(1));
          state_next = scpcsr_pkg::ST_CK_PERM;
        end
      end

      scpcsr_pkg::ST_CK_ROW: begin
        if (sri_rd == '0 || 32'(sri_rd) > 32'(m_eff)) begin
          err_next = 1'b1; state_next = scpcsr_pkg::ST_FIN;
        end else if (j + LW'(1) != e_ptr) begin
          j_next = j + LW'(1);
          sri_re = 1'b1; sri_ra = NAW'(j + LW'(1));
        end else if (col == n_eff) begin
          state_next = scpcsr_pkg::ST_CK_TAIL;
        end else begin
          col_next = col + DAW'(1);
          prm_re = 1'b1; prm_ra = PAW'(col + DAW'(1));
          state_next = scpcsr_pkg::ST_CK_PERM;
        end
      end

      scpcsr_pkg::ST_CK_TAIL: begin
        col_next = DAW'(1); count_next = NCW'(1);
        if (total != TW'(nz_eff)) begin
          err_next = 1'b1; state_next = scpcsr_pkg::ST_FIN;
        end else if (n_eff == '0) begin
          state_next = scpcsr_pkg::ST_CP_LAST;
        end else begin
          prm_re = 1'b1; prm_ra = PAW'(1);
          state_next = scpcsr_pkg::ST_CP_PERM;
        end
      end

      // ---- permuted column copy ----
      scpcsr_pkg::ST_CP_PERM: begin
        src_next = prm_rd;
        scs_re = 1'b1; scs_ra = DAW'(prm_rd);
        state_next = scpcsr_pkg::ST_CP_START;
      end

      scpcsr_pkg::ST_CP_START: begin
        s_ptr_next = scs_rd;
        scs_re = 1'b1; scs_ra = DAW'(src) + DAW'(1);
        state_next = scpcsr_pkg::ST_CP_END;
      end

      scpcsr_pkg::ST_CP_END: begin
        e_ptr_next = scs_rd;
        pcs_we = 1'b1;
        if (scs_rd > s_ptr) begin
          j_next = s_ptr;
          sri_re = 1'b1; sri_ra = NAW'(s_ptr);
          state_next = scpcsr_pkg::ST_CP_WR;
        end else if (col == n_eff) begin
          state_next = scpcsr_pkg::ST_CP_LAST;
        end else begin
          col_next = col + DAW'(1);
          prm_re = 1'b1; prm_ra = PAW'(col + DAW'(1));
          state_next = scpcsr_pkg::ST_CP_PERM;
        end
      end

      scpcsr_pkg::ST_CP_WR: begin
        pri_we = 1'b1;
        count_next = count + NCW'(1);
        if (j + LW'(1) != e_ptr) begin
          j_next = j + LW'(1);
          sri_re = 1'b1; sri_ra = NAW'(j + LW'(1));
        end else if (col == n_eff) begin
          state_next = scpcsr_pkg::ST_CP_LAST;
        end else begin
          col_next = col + DAW'(1);
          prm_re = 1'b1; prm_ra = PAW'(col + DAW'(1));
          state_next = scpcsr_pkg::ST_CP_PERM;
        end
      end

      scpcsr_pkg::ST_CP_LAST: begin
        pcs_we = 1'b1; pcs_wa = n_eff + DAW'(1); pcs_wd = LW'(32'(nz_eff) + 1);
        col_next = DAW'(1);
        state_next = scpcsr_pkg::ST_CLR;
      end

      // ---- row histogram ----
      scpcsr_pkg::ST_CLR: begin
        rn_we = 1'b1;
        k_next = NCW'(1);
        if (col == m_eff + DAW'(1)) begin
          if (nz_eff == '0) begin
            state_next = scpcsr_pkg::ST_PF_START;
          end else begin
            pri_re = 1'b1; pri_ra = NAW'(1);
            state_next = scpcsr_pkg::ST_HI_ROW;
          end
        end else begin
          col_next = col + DAW'(1);
        end
      end

      scpcsr_pkg::ST_HI_ROW: begin
        rr_next = pri_rd;
        rn_re = 1'b1; rn_ra = DAW'(pri_rd);
        state_next = scpcsr_pkg::ST_HI_WR;
      end

      scpcsr_pkg::ST_HI_WR: begin
        rn_we = 1'b1; rn_wa = DAW'(rr); rn_wd = rn_rd + NCW'(1);
        if (k == nz_eff) begin
          state_next = scpcsr_pkg::ST_PF_START;
        end else begin
          k_next = k + NCW'(1);
          pri_re = 1'b1; pri_ra = NAW'(k + NCW'(1));
          state_next = scpcsr_pkg::ST_HI_ROW;
        end
      end

      // ---- prefix sum into row starts ----
      scpcsr_pkg::ST_PF_START: begin
        col_next = DAW'(1); count_next = NCW'(1);
        if (m_eff == '0) begin
          state_next = scpcsr_pkg::ST_PF_LAST;
        end else begin
          rn_re = 1'b1; rn_ra = DAW'(1);
          state_next = scpcsr_pkg::ST_PF_WR;
        end
      end

      scpcsr_pkg::ST_PF_WR: begin
        rs_we = 1'b1;
        rn_we = 1'b1; rn_wd = count;
        count_next = count + rn_rd;
        if (col == m_eff) begin
          state_next = scpcsr_pkg::ST_PF_LAST;
        end else begin
          col_next = col + DAW'(1);
          rn_re = 1'b1; rn_ra = col + DAW'(1);
        end
      end

      scpcsr_pkg::ST_PF_LAST: begin
        rs_we = 1'b1; rs_wa = m_eff + DAW'(1); rs_wd = LW'(32'(nz_eff) + 1);
        k_next = NCW'(1);
        if (nz_eff == '0) begin
          state_next = scpcsr_pkg::ST_FIN;
        end else begin
          pri_re = 1'b1; ent_re = 1'b1; pri_ra = NAW'(1);
          state_next = scpcsr_pkg::ST_SC_ROW;
        end
      end

      // ---- scatter into row form ----
      scpcsr_pkg::ST_SC_ROW: begin
        rr_next = pri_rd;
        rn_re = 1'b1; rn_ra = DAW'(pri_rd);
        state_next = scpcsr_pkg::ST_SC_WR;
      end

      scpcsr_pkg::ST_SC_WR: begin
        rc_we = 1'b1;
        rn_we = 1'b1; rn_wa = DAW'(rr); rn_wd = rn_rd + NCW'(1);
        if (k == nz_eff) begin
          state_next = scpcsr_pkg::ST_FIN;
        end else begin
          k_next = k + NCW'(1);
          pri_re = 1'b1; ent_re = 1'b1; pri_ra = NAW'(k + NCW'(1));
          state_next = scpcsr_pkg::ST_SC_ROW;
        end
      end

      scpcsr_pkg::ST_FIN: begin
        out_load = 1'b1; out_status_next = err;
        state_next = scpcsr_pkg::ST_IDLE;
      end

      default: state_next = scpcsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpcsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_reg <= op_reg_next;
    col    <= col_next;
    src    <= src_next;
    s_ptr  <= s_ptr_next;
    e_ptr  <= e_ptr_next;
    j      <= j_next;
    total  <= total_next;
    count  <= count_next;
    k      <= k_next;
    rr     <= rr_next;
    err    <= err_next;
  end

  // result register: filled only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_link   <= out_link_next;
      out_value  <= out_value_next;
      out_status <= out_status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_value, out_link};
  assign m_tuser  = out_status;
endmodule

>>> sv/scpcsr_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module scpcsr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> tb/tb_sparse_column_permute_csr_build.sv
`timescale 1ns / 100ps
// Testbench for sparse_column_permute_csr_build: loads matrices, permutes and
// converts them, reads back both result forms and checks every result.
// Depends on scpcsr_pkg and the block's RTL only.
module tb_sparse_column_permute_csr_build;

  localparam int IDLE_LIMIT = 400000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int MAX_D = scpcsr_pkg::DEF_MAX_DIM;
  localparam int MAX_N = scpcsr_pkg::DEF_MAX_NONZEROS;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // position[12:0], link[25:13], value_bits[89:26], zero pad
  logic [2:0]  s_tuser;   // operation[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // result_link[12:0], result_value[76:13], zero pad
  logic        m_tuser;   // status
  logic        cfg_we;
  logic [scpcsr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scpcsr_pkg::CFG_W-1:0]     cfg_wdata;

  sparse_column_permute_csr_build u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: registers and all stores
  // ---------------------------------------------------------------------------
  logic [10:0] row_reg, col_reg;
  logic [12:0] nz_reg;

  logic [12:0] src_colptr [0:MAX_D+1];
  logic [10:0] src_row    [0:MAX_N];
  logic [63:0] src_val    [0:MAX_N];
  logic [10:0] col_perm   [0:MAX_D];
  logic [12:0] perm_colptr[0:MAX_D+1];
  logic [10:0] perm_row   [0:MAX_N];
  logic [63:0] perm_val   [0:MAX_N];
  logic [12:0] csr_rowptr [0:MAX_D+1];
  logic [10:0] csr_col    [0:MAX_N];
  logic [63:0] csr_val    [0:MAX_N];
  int          entry_col  [0:MAX_N];
  int          row_fill   [0:MAX_D+1];

  // reads are legal only while the last good build matches the registers
  bit          built;
  logic [10:0] built_rows, built_cols;
  logic [12:0] built_nz;

  function automatic int eff_rows();
    return (row_reg > MAX_D) ? MAX_D : int'(row_reg);
  endfunction
  function automatic int eff_cols();
    return (col_reg > MAX_D) ? MAX_D : int'(col_reg);
  endfunction
  function automatic int eff_nz();
    return (nz_reg > MAX_N) ? MAX_N : int'(nz_reg);
  endfunction
  function automatic bit reads_legal();
    return built && built_rows == row_reg && built_cols == col_reg && built_nz == nz_reg;
  endfunction

  // Permute columns, then bucket entries by row. Returns 1 when a check fails;
  // nothing is touched in that case.
  function automatic bit permute_and_convert();
    int n, m, nz, total, cnt, src, s, e, r, c, d;
    n = eff_cols(); m = eff_rows(); nz = eff_nz(); total = 0;
    for (int i = 1; i <= n; i++) begin
      src = col_perm[i];
      if (src < 1 || src > n) return 1'b1;
      s = src_colptr[src]; e = src_colptr[src+1];
      if (e > s) begin
        if (s < 1 || e - 1 > nz) return 1'b1;
        total += e - s;
        if (total > nz) return 1'b1;
        for (int j = s; j < e; j++) begin
          r = src_row[j];
          if (r < 1 || r > m) return 1'b1;
        end
      end
    end
    if (total != nz) return 1'b1;

    cnt = 1;
    for (int i = 1; i <= n; i++) begin
      src = col_perm[i];
      s = src_colptr[src]; e = src_colptr[src+1];
      perm_colptr[i] = cnt;
      for (int j = s; j < e; j++) begin
        perm_row[cnt] = src_row[j];
        perm_val[cnt] = src_val[j];
        entry_col[cnt] = i;
        cnt++;
      end
    end
    perm_colptr[n+1] = nz + 1;

    for (int i = 1; i <= m + 1; i++) row_fill[i] = 0;
    for (int k = 1; k <= nz; k++) row_fill[perm_row[k]]++;
    cnt = 1;
    for (int i = 1; i <= m; i++) begin
      c = row_fill[i];
      csr_rowptr[i] = cnt;
      row_fill[i] = cnt;
      cnt += c;
    end
    csr_rowptr[m+1] = nz + 1;
    for (int k = 1; k <= nz; k++) begin
      d = row_fill[perm_row[k]];
      row_fill[perm_row[k]]++;
      csr_col[d] = entry_col[k];
      csr_val[d] = perm_val[k];
    end
    return 1'b0;
  endfunction

  // One command through the shadow copy; updates state like the block does.
  function automatic void apply_command(input scpcsr_pkg::op_t op, input int pos,
                                        input int lnk, input logic [63:0] val,
                                        output int rl, output logic [63:0] rv,
                                        output bit st);
    int n, m, nz;
    n = eff_cols(); m = eff_rows(); nz = eff_nz();
    rl = 0; rv = '0; st = 1'b0;
    case (op)
      scpcsr_pkg::OP_LOAD_COLPTR: begin
        if (pos >= 1 && pos <= n + 1) src_colptr[pos] = lnk;
        else st = 1'b1;
      end
      scpcsr_pkg::OP_LOAD_ENTRY: begin
        if (pos >= 1 && pos <= nz && lnk >= 1 && lnk <= m) begin
          src_row[pos] = lnk;
          src_val[pos] = val;
        end else st = 1'b1;
      end
      scpcsr_pkg::OP_LOAD_PERM: begin
        if (pos >= 1 && pos <= n && lnk >= 1 && lnk <= n) col_perm[pos] = lnk;
        else st = 1'b1;
      end
      scpcsr_pkg::OP_RUN: begin
        st = permute_and_convert();
        if (!st) begin
          built = 1'b1;
          built_rows = row_reg; built_cols = col_reg; built_nz = nz_reg;
        end
      end
      scpcsr_pkg::OP_READ_COLPTR: begin
        if (pos >= 1 && pos <= n + 1) rl = perm_colptr[pos];
        else st = 1'b1;
      end
      scpcsr_pkg::OP_READ_CSC: begin
        if (pos >= 1 && pos <= nz) begin
          rl = perm_row[pos]; rv = perm_val[pos];
        end else st = 1'b1;
      end
      scpcsr_pkg::OP_READ_ROWPTR: begin
        if (pos >= 1 && pos <= m + 1) rl = csr_rowptr[pos];
        else st = 1'b1;
      end
      default: begin
        if (pos >= 1 && pos <= nz) begin
          rl = csr_col[pos]; rv = csr_val[pos];
        end else st = 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results and checking
  // ---------------------------------------------------------------------------
  typedef struct {
    scpcsr_pkg::op_t op;
    int              link;
    logic [63:0]     value;
    bit              status;
  } result_t;

  result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int op_hist[8];
  int ok_runs = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH t=%0t %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, link", m_tdata[12:0], 0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[12:0] != exp_r.link[12:0])
          report_mismatch({exp_r.op.name(), " result_link"}, m_tdata[12:0], exp_r.link);
        if (m_tdata[76:13] != exp_r.value)
          report_mismatch({exp_r.op.name(), " result_value"}, m_tdata[76:13], exp_r.value);
        if (m_tuser != exp_r.status)
          report_mismatch({exp_r.op.name(), " status"}, m_tuser, exp_r.status);
      end
    end
  end

  // watchdog: no transfer on either side for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  bit hold_request = 0;
  initial begin
    int mode_left, stall_pct;
    m_tready = 1'b0;
    mode_left = 0; stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;      // no stalls at all
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      m_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int items_sent = 0;

  // Drive one command; expectation is taken from the shadow copy unless a
  // typed answer is given.
  task automatic send_cmd(input scpcsr_pkg::op_t op, input int pos, input int lnk,
                          input logic [63:0] val, input bit typed = 0,
                          input int t_link = 0, input logic [63:0] t_val = '0,
                          input bit t_st = 0);
    result_t r;
    int rl;
    logic [63:0] rv;
    bit st;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {6'd0, val, lnk[12:0], pos[12:0]};
    do @(posedge clk); while (!s_tready);
    apply_command(op, pos, lnk, val, rl, rv, st);
    r.op = op;
    if (typed) begin
      r.link = t_link; r.value = t_val; r.status = t_st;
    end else begin
      r.link = rl; r.value = rv; r.status = st;
    end
    pending_results.push_back(r);
    op_hist[op]++;
    items_sent++;
    if (op == scpcsr_pkg::OP_RUN && !st) ok_runs++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input scpcsr_pkg::reg_idx_t idx, input int v);
    wait_drained();
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = v[12:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      scpcsr_pkg::REG_ROW_COUNT: row_reg = v[10:0];
      scpcsr_pkg::REG_COL_COUNT: col_reg = v[10:0];
      scpcsr_pkg::REG_NZ_COUNT:  nz_reg  = v[12:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Load with an address or link outside the legal range: always rejected, no write.
  task automatic send_bad_load();
    int n, m, nz;
    n = eff_cols(); m = eff_rows(); nz = eff_nz();
    case ($urandom_range(0, 3))
      0: send_cmd(scpcsr_pkg::OP_LOAD_COLPTR,
                  ($urandom_range(0, 1) ? 0 : $urandom_range(n + 2, 8191)),
                  $urandom_range(0, 8191), rand64());
      1: send_cmd(scpcsr_pkg::OP_LOAD_ENTRY,
                  ($urandom_range(0, 1) ? 0 : $urandom_range(nz + 1, 8191)),
                  $urandom_range(0, 8191), rand64());
      2: send_cmd(scpcsr_pkg::OP_LOAD_ENTRY, $urandom_range(0, 8191),
                  ($urandom_range(0, 1) ? 0 : $urandom_range(m + 1, 8191)), rand64());
      default: send_cmd(scpcsr_pkg::OP_LOAD_PERM, $urandom_range(0, 8191),
                        ($urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 8191)), rand64());
    endcase
  endtask

  task automatic send_noise();
    if (reads_legal() && $urandom_range(0, 1))
      send_cmd(scpcsr_pkg::op_t'($urandom_range(4, 7)), $urandom_range(0, 8191),
               $urandom_range(0, 8191), rand64());
    else
      send_bad_load();
  endtask

  // flavors of a matrix job
  typedef enum int {JOB_GOOD, JOB_DUP_PERM, JOB_BAD_SIZES, JOB_SHRINK_ROWS,
                    JOB_SHRINK_COLS} job_kind_t;

  int col_size[0:MAX_D+1];
  int perm_tmp[0:MAX_D];

  // Configure, load a full matrix in random order with noise mixed in, run,
  // then read both result forms.
  task automatic matrix_job(input int rows_v, input int cols_v, input int nz_v,
                            input job_kind_t kind, input bit hold_off);
    int n, m, nz, acc, a, b, t, nreads;
    int order[$];
    write_reg(scpcsr_pkg::REG_ROW_COUNT, rows_v);
    write_reg(scpcsr_pkg::REG_COL_COUNT, cols_v);
    write_reg(scpcsr_pkg::REG_NZ_COUNT, nz_v);
    n = eff_cols(); m = eff_rows(); nz = eff_nz();

    // column sizes summing to nz
    for (int c = 1; c <= n; c++) col_size[c] = 0;
    if (n > 0) for (int k = 0; k < nz; k++) col_size[$urandom_range(1, n)]++;
    acc = 1;
    for (int c = 1; c <= n + 1; c++) begin
      order.push_back(c);
      col_size[0] = acc;           // start of column c
      if (c <= n) acc += col_size[c];
      // stash start pointers in row_fill scratch
      row_fill[c] = col_size[0];
    end
    if (kind == JOB_BAD_SIZES && nz > 0) row_fill[n+1] = row_fill[n+1] - 1;
    order.shuffle();
    foreach (order[i]) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_cmd(scpcsr_pkg::OP_LOAD_COLPTR, order[i], row_fill[order[i]], rand64());
    end

    if (hold_off) hold_request = 1;
    for (int k = 1; k <= nz; k++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_cmd(scpcsr_pkg::OP_LOAD_ENTRY, k, $urandom_range(1, m), rand64());
    end

    for (int c = 1; c <= n; c++) perm_tmp[c] = c;
    for (int c = n; c > 1; c--) begin
      a = $urandom_range(1, c);
      t = perm_tmp[c]; perm_tmp[c] = perm_tmp[a]; perm_tmp[a] = t;
    end
    if (kind == JOB_DUP_PERM && n > 1) begin
      a = $urandom_range(1, n); b = $urandom_range(1, n);
      perm_tmp[a] = perm_tmp[b];
    end
    for (int c = 1; c <= n; c++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_cmd(scpcsr_pkg::OP_LOAD_PERM, c, perm_tmp[c], rand64());
    end

    if (kind == JOB_SHRINK_ROWS && rows_v > 1 && rows_v <= MAX_D)
      write_reg(scpcsr_pkg::REG_ROW_COUNT, rows_v - 1);
    if (kind == JOB_SHRINK_COLS && cols_v > 1 && cols_v <= MAX_D)
      write_reg(scpcsr_pkg::REG_COL_COUNT, cols_v - 1);
    send_cmd(scpcsr_pkg::OP_RUN, $urandom_range(0, 8191), $urandom_range(0, 8191),
             rand64());

    if (reads_legal()) begin
      n = eff_cols(); m = eff_rows(); nz = eff_nz();
      nreads = $urandom_range(6, 30);
      for (int i = 0; i < nreads; i++) begin
        a = $urandom_range(4, 7);
        if ($urandom_range(0, 5) == 0) b = $urandom_range(0, 8191);
        else if (a == scpcsr_pkg::OP_READ_COLPTR) b = $urandom_range(1, n + 1);
        else if (a == scpcsr_pkg::OP_READ_ROWPTR) b = $urandom_range(1, m + 1);
        else b = (nz > 0) ? $urandom_range(1, nz) : 1;
        send_cmd(scpcsr_pkg::op_t'(a), b, $urandom_range(0, 8191), rand64());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: reset setting (1 row, 1 column, no entries)
  // ---------------------------------------------------------------------------
  typedef struct {
    scpcsr_pkg::op_t op;
    int              pos;
    int              lnk;
    logic [63:0]     val;
    bit              typed;
    int              e_link;
    logic [63:0]     e_val;
    bit              e_st;
  } directed_t;

  localparam logic [63:0] ONES = '1;

  directed_t directed_rows[] = '{
    '{scpcsr_pkg::OP_LOAD_COLPTR, 1,    1,    64'd0, 1, 0, 64'd0, 0},
    '{scpcsr_pkg::OP_LOAD_COLPTR, 2,    1,    ONES,  1, 0, 64'd0, 0},
    '{scpcsr_pkg::OP_LOAD_COLPTR, 3,    1,    64'd0, 1, 0, 64'd0, 1},   // past col_count+1
    '{scpcsr_pkg::OP_LOAD_COLPTR, 0,    8191, 64'd0, 1, 0, 64'd0, 1},   // position zero
    '{scpcsr_pkg::OP_LOAD_ENTRY,  1,    1,    ONES,  1, 0, 64'd0, 1},   // no entries in use
    '{scpcsr_pkg::OP_LOAD_ENTRY,  8191, 8191, ONES,  1, 0, 64'd0, 1},
    '{scpcsr_pkg::OP_LOAD_PERM,   1,    0,    64'd0, 1, 0, 64'd0, 1},   // source column zero
    '{scpcsr_pkg::OP_LOAD_PERM,   1,    2,    64'd0, 1, 0, 64'd0, 1},   // source past col_count
    '{scpcsr_pkg::OP_LOAD_PERM,   2,    1,    64'd0, 1, 0, 64'd0, 1},   // slot past col_count
    '{scpcsr_pkg::OP_LOAD_PERM,   1,    1,    64'd0, 1, 0, 64'd0, 0},
    '{scpcsr_pkg::OP_RUN,         0,    0,    64'd0, 1, 0, 64'd0, 0},   // empty matrix builds
    '{scpcsr_pkg::OP_READ_COLPTR, 1,    0,    64'd0, 1, 1, 64'd0, 0},
    '{scpcsr_pkg::OP_READ_COLPTR, 2,    0,    64'd0, 1, 1, 64'd0, 0},
    '{scpcsr_pkg::OP_READ_COLPTR, 3,    0,    64'd0, 1, 0, 64'd0, 1},
    '{scpcsr_pkg::OP_READ_CSC,    1,    0,    64'd0, 1, 0, 64'd0, 1},
    '{scpcsr_pkg::OP_READ_ROWPTR, 1,    0,    64'd0, 1, 1, 64'd0, 0},
    '{scpcsr_pkg::OP_READ_ROWPTR, 2,    8191, ONES,  1, 1, 64'd0, 0},
    '{scpcsr_pkg::OP_READ_ROWPTR, 3,    0,    64'd0, 1, 0, 64'd0, 1},
    '{scpcsr_pkg::OP_READ_CSR,    0,    0,    64'd0, 1, 0, 64'd0, 1},
    '{scpcsr_pkg::OP_READ_CSR,    8191, 8191, ONES,  1, 0, 64'd0, 1}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int rows_v, cols_v, nz_v, random_start;
    job_kind_t kind;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    row_reg = 11'd1; col_reg = 11'd1; nz_reg = 13'd0; built = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].lnk,
               directed_rows[i].val, directed_rows[i].typed, directed_rows[i].e_link,
               directed_rows[i].e_val, directed_rows[i].e_st);

    // an index past the register list changes nothing
    write_reg(scpcsr_pkg::REG_NONE, 13'h1FFF);
    send_cmd(scpcsr_pkg::OP_READ_ROWPTR, 1, 0, 64'd0);

    // small example matrices, every job flavor; the first one runs under a
    // long receiver hold-off while entries stream in
    random_start = items_sent;
    matrix_job(12, 10, 30, JOB_GOOD, 1'b1);
    while (items_sent - random_start < 600) begin
      kind = job_kind_t'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) kind = JOB_GOOD;
      rows_v = $urandom_range(0, 12);
      cols_v = $urandom_range(0, 10);
      nz_v   = $urandom_range(0, 30);
      if (rows_v == 0 || cols_v == 0) nz_v = 0;  // nothing could be loaded
      matrix_job(rows_v, cols_v, nz_v, kind, 1'b0);
    end

    // register extremes: saturating counts, loads and reads at the range edges
    write_reg(scpcsr_pkg::REG_ROW_COUNT, 2047);
    write_reg(scpcsr_pkg::REG_COL_COUNT, 2047);
    write_reg(scpcsr_pkg::REG_NZ_COUNT, 8191);
    send_cmd(scpcsr_pkg::OP_LOAD_COLPTR, MAX_D + 1, 8191, rand64());
    send_cmd(scpcsr_pkg::OP_LOAD_COLPTR, MAX_D + 2, 1, rand64());
    send_cmd(scpcsr_pkg::OP_LOAD_ENTRY, MAX_N, MAX_D, ONES);
    send_cmd(scpcsr_pkg::OP_LOAD_ENTRY, MAX_N + 1, 1, ONES);
    send_cmd(scpcsr_pkg::OP_LOAD_ENTRY, 1, MAX_D + 1, ONES);
    send_cmd(scpcsr_pkg::OP_LOAD_PERM, MAX_D, MAX_D, rand64());
    send_cmd(scpcsr_pkg::OP_LOAD_PERM, MAX_D + 1, 1, rand64());
    send_cmd(scpcsr_pkg::OP_LOAD_PERM, 1, MAX_D + 1, rand64());
    send_cmd(scpcsr_pkg::OP_READ_COLPTR, MAX_D + 2, 0, rand64());
    send_cmd(scpcsr_pkg::OP_READ_ROWPTR, MAX_D + 2, 0, rand64());
    send_cmd(scpcsr_pkg::OP_READ_CSC, MAX_N + 1, 0, rand64());
    send_cmd(scpcsr_pkg::OP_READ_CSR, 8191, 0, rand64());

    matrix_job(1, 1, 1, JOB_GOOD, 1'b0);
    matrix_job(0, 0, 0, JOB_GOOD, 1'b0);

    wait_drained();
    repeat (40) @(negedge clk);
    $display("covered %0d commands (colptr/entry/perm loads %0d/%0d/%0d, runs %0d, %0d good)",
             items_sent, op_hist[scpcsr_pkg::OP_LOAD_COLPTR],
             op_hist[scpcsr_pkg::OP_LOAD_ENTRY], op_hist[scpcsr_pkg::OP_LOAD_PERM],
             op_hist[scpcsr_pkg::OP_RUN], ok_runs);
    $display("reads colptr/csc/rowptr/csr %0d/%0d/%0d/%0d, results checked %0d",
             op_hist[scpcsr_pkg::OP_READ_COLPTR], op_hist[scpcsr_pkg::OP_READ_CSC],
             op_hist[scpcsr_pkg::OP_READ_ROWPTR], op_hist[scpcsr_pkg::OP_READ_CSR],
             results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
